[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the sorted record table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define SRT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted record table: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define SRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted record table: next-cycle check failed");

`endif

[rtl/core/srt_pkg.sv]
// Types and constants of the sorted record table.
package srt_pkg;

  localparam int KEY_W      = 32;
  localparam int NAME_LOW_W = 64;
  localparam int NAME_MID_W = 64;
  localparam int NAME_HI_W  = 32;
  localparam int POS_W      = 5;
  localparam int TOTAL_W    = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [NAME_LOW_W-1:0] name_low;
    logic [NAME_MID_W-1:0] name_mid;
    logic [NAME_HI_W-1:0]  name_high;
  } record_t;

  typedef struct packed {
    status_e               status;
    logic [POS_W-1:0]      position;
    logic [TOTAL_W-1:0]    total;
    logic [NAME_LOW_W-1:0] name_low;
    logic [NAME_MID_W-1:0] name_mid;
    logic [NAME_HI_W-1:0]  name_high;
  } res_t;

endpackage

[rtl/core/srt_req_if.sv]
// Request channel of the sorted record table: valid, ready and the command payload.
interface srt_req_if import srt_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [KEY_W-1:0]      key;
  logic [NAME_LOW_W-1:0] name_low;
  logic [NAME_MID_W-1:0] name_mid;
  logic [NAME_HI_W-1:0]  name_high;

  modport source (output valid, cmd, key, name_low, name_mid, name_high, input ready);
  modport sink (input valid, cmd, key, name_low, name_mid, name_high, output ready);
endinterface

[rtl/core/srt_rsp_if.sv]
// Result channel of the sorted record table: valid, ready and the result payload.
interface srt_rsp_if import srt_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [POS_W-1:0]      position;
  logic [TOTAL_W-1:0]    entry_total;
  logic [NAME_LOW_W-1:0] out_name_low;
  logic [NAME_MID_W-1:0] out_name_mid;
  logic [NAME_HI_W-1:0]  out_name_high;

  modport source (output valid, status, position, entry_total, out_name_low, out_name_mid,
                  out_name_high, input ready);
  modport sink (input valid, status, position, entry_total, out_name_low, out_name_mid,
                out_name_high, output ready);
endinterface

[rtl/core/srt_mem.sv]
// Record memory: one write port and one read port with registered read data.
module srt_mem import srt_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  record_t       wdata,
  input  logic [AW-1:0] raddr,
  output record_t       rdata
);

  record_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/srt_seq.sv]
// Sequencer: scans the record memory for the key, then shifts records one per cycle.
module srt_seq import srt_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst,
  srt_req_if.sink       req,
  output logic [AW-1:0] rd_addr,
  input  record_t       rd_data,
  output logic          we,
  output logic [AW-1:0] waddr,
  output record_t       wdata,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_PLACE,
    S_RESP
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic          cmd_r;
  record_t       req_r;

  logic last;
  logic hit;
  logic above;

  assign last      = (idx + CW'(1)) == count;
  assign hit       = rd_data.key == req_r.key;
  assign above     = rd_data.key > req_r.key;
  assign req.ready = state == S_IDLE;
  assign res_valid = state == S_RESP;

  // Read address for the next cycle and the write of this cycle.
  always_comb begin
    rd_addr = '0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = rd_data;
    unique case (state)
      S_IDLE: begin
        rd_addr = '0;
      end
      S_SCAN: begin
        if (hit) begin
          if (cmd_r == CMD_DELETE && !last) rd_addr = AW'(idx + CW'(1));
        end else if (above || last) begin
          if (cmd_r == CMD_INSERT && above) rd_addr = AW'(count - CW'(1));
        end else begin
          rd_addr = AW'(idx + CW'(1));
        end
      end
      S_SHUP: begin
        we    = 1'b1;
        waddr = AW'(idx);
        if (idx != pos + CW'(1)) rd_addr = AW'(idx - CW'(2));
      end
      S_SHDN: begin
        we    = 1'b1;
        waddr = AW'(idx);
        if (idx + CW'(2) != count) rd_addr = AW'(idx + CW'(2));
      end
      S_PLACE: begin
        we    = 1'b1;
        waddr = AW'(pos);
        wdata = req_r;
      end
      S_RESP: begin
        rd_addr = '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_r        <= req.cmd;
            req_r        <= '{req.key, req.name_low, req.name_mid, req.name_high};
            idx          <= '0;
            pos          <= '0;
            res.position <= '0;
            res.total    <= TOTAL_W'(count);
            res.name_low <= '0;
            res.name_mid <= '0;
            res.name_high <= '0;
            if (req.cmd == CMD_INSERT && count == CW'(CAPACITY)) begin
              res.status <= ST_FULL;
              state      <= S_RESP;
            end else if (count == '0) begin
              if (req.cmd == CMD_INSERT) begin
                state <= S_PLACE;
              end else begin
                res.status <= ST_MISSING;
                state      <= S_RESP;
              end
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            res.position <= POS_W'(idx);
            if (cmd_r == CMD_INSERT) begin
              res.status <= ST_DUP;
              state      <= S_RESP;
            end else begin
              res.name_low  <= rd_data.name_low;
              res.name_mid  <= rd_data.name_mid;
              res.name_high <= rd_data.name_high;
              if (last) begin
                count      <= count - CW'(1);
                res.total  <= TOTAL_W'(count - CW'(1));
                res.status <= ST_DONE;
                state      <= S_RESP;
              end else begin
                state <= S_SHDN;
              end
            end
          end else if (above) begin
            if (cmd_r == CMD_INSERT) begin
              pos   <= idx;
              idx   <= count;
              state <= S_SHUP;
            end else begin
              res.status <= ST_MISSING;
              state      <= S_RESP;
            end
          end else if (last) begin
            if (cmd_r == CMD_INSERT) begin
              pos   <= count;
              state <= S_PLACE;
            end else begin
              res.status <= ST_MISSING;
              state      <= S_RESP;
            end
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_SHUP: begin
          if (idx == pos + CW'(1)) begin
            state <= S_PLACE;
          end else begin
            idx <= idx - CW'(1);
          end
        end
        S_SHDN: begin
          if (idx + CW'(2) == count) begin
            count      <= count - CW'(1);
            res.total  <= TOTAL_W'(count - CW'(1));
            res.status <= ST_DONE;
            state      <= S_RESP;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_PLACE: begin
          count        <= count + CW'(1);
          res.total    <= TOTAL_W'(count + CW'(1));
          res.position <= POS_W'(pos);
          res.status   <= ST_DONE;
          state        <= S_RESP;
        end
        S_RESP: begin
          if (res_ready) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/sorted_record_table_core.sv]
// Top level of the sorted record table: sequencer, record memory and result register.
//
//   channel   modport  direction  payload
//   req       sink     in         cmd, key, name_low, name_mid, name_high
//   rsp       source   out        status, position, entry_total, out_name_*
//
// One request is worked at a time. A request is taken in the idle state, then
// the sequencer scans the record memory one key per cycle through its single
// read port. A delete shifts records down from where the scan stopped; an
// insert shifts them up from the top down to where the scan stopped, then
// stores the new record, and the result then goes to the output register, so
// an insert that lands at the front is the worst case. Refused inserts into a
// full table and requests on an empty table skip the scan and the shift.
// Reset (rst, synchronous) empties the table at once; the memory needs no
// clearing pass since only entries below the record count are ever read.
// A stalled rsp channel holds its result in the output register while the
// next request is worked; that request then waits for the register to free.
`include "assert_macros.svh"

module sorted_record_table_core import srt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst,
  srt_req_if.sink   req,
  srt_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] waddr;
  logic          we;
  record_t       wdata;
  record_t       rd_data;
  logic          res_valid;
  logic          res_ready;
  res_t          res;

  // Output register: holds one finished result until the consumer takes it.
  logic out_valid;
  res_t out_res;

  // A refused insert into a full table or a miss is being offered.
  logic refused;

  // The sequencer may hand over a result whenever the register is empty or
  // is being emptied in this same cycle.
  assign res_ready = !out_valid || rsp.ready;

  srt_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  srt_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_res.status;
  assign rsp.position      = out_res.position;
  assign rsp.entry_total   = out_res.total;
  assign rsp.out_name_low  = out_res.name_low;
  assign rsp.out_name_mid  = out_res.name_mid;
  assign rsp.out_name_high = out_res.name_high;

  assign refused = rsp.valid && (rsp.status == ST_FULL || rsp.status == ST_MISSING);

  // Once a request is taken, the sequencer is busy until its result is out.
  `SRT_ASSERT_NEXT(a_busy_after_take, req.valid && req.ready, !req.ready)
  // A result offered by the sequencer stays put until the register takes it.
  `SRT_ASSERT_NEXT(a_res_held, res_valid && !res_ready, res_valid && $stable(res))
  // Refused inserts into a full table and misses report position zero.
  `SRT_ASSERT_IMPL(a_refused_pos, refused, rsp.position == '0)

endmodule

[tb/srt_result_checker.sv]
// Result checker for the sorted record table: predicts each result and compares it.
`timescale 1ns / 100ps

module srt_result_checker import srt_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic clk,
  input  logic rst,
  srt_req_if   req,
  srt_rsp_if   rsp,
  output int   fail_count,
  output int   pending,
  output int   checked
);

  // Shadow copy of the table, entries 0 .. held_count-1 in ascending key order.
  record_t rec_mem [CAPACITY];
  int      held_count;
  res_t    expected_q [$];
  int      fails = 0;
  int      results = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic res_t apply_request(input logic op, input record_t rec);
    res_t outcome;
    int   hit;
    int   slot;
    outcome = '0;
    hit     = held_count;
    for (int i = held_count - 1; i >= 0; i--) begin
      if (rec_mem[i].key == rec.key) hit = i;
    end
    if (op == CMD_INSERT) begin
      if (held_count >= CAPACITY) begin
        outcome.status = ST_FULL;
      end else if (hit < held_count) begin
        outcome.status   = ST_DUP;
        outcome.position = POS_W'(hit);
      end else begin
        slot = held_count;
        for (int i = held_count - 1; i >= 0; i--) begin
          if (rec.key < rec_mem[i].key) slot = i;
        end
        for (int i = held_count; i > slot; i--) rec_mem[i] = rec_mem[i - 1];
        rec_mem[slot]    = rec;
        held_count++;
        outcome.status   = ST_DONE;
        outcome.position = POS_W'(slot);
      end
    end else begin
      if (hit >= held_count) begin
        outcome.status = ST_MISSING;
      end else begin
        outcome.status    = ST_DONE;
        outcome.position  = POS_W'(hit);
        outcome.name_low  = rec_mem[hit].name_low;
        outcome.name_mid  = rec_mem[hit].name_mid;
        outcome.name_high = rec_mem[hit].name_high;
        for (int i = hit; i + 1 < held_count; i++) rec_mem[i] = rec_mem[i + 1];
        held_count--;
      end
    end
    outcome.total = TOTAL_W'(held_count);
    return outcome;
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", field, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : watch
    record_t rec;
    res_t    want;
    if (rst) begin
      held_count = 0;
      expected_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        rec.key       = req.key;
        rec.name_low  = req.name_low;
        rec.name_mid  = req.name_mid;
        rec.name_high = req.name_high;
        expected_q.push_back(apply_request(req.cmd, rec));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          fails++;
        end else begin
          want = expected_q.pop_front();
          results++;
          check_field("status", 64'(want.status), 64'(rsp.status));
          check_field("position", 64'(want.position), 64'(rsp.position));
          check_field("entry_total", 64'(want.total), 64'(rsp.entry_total));
          check_field("out_name_low", want.name_low, rsp.out_name_low);
          check_field("out_name_mid", want.name_mid, rsp.out_name_mid);
          check_field("out_name_high", 64'(want.name_high), 64'(rsp.out_name_high));
        end
      end
    end
    pending    <= expected_q.size();
    fail_count <= fails;
    checked    <= results;
  end

endmodule

[tb/tb_sorted_record_table_core.sv]
// Testbench top of the sorted record table: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module tb_sorted_record_table_core;
  import srt_pkg::*;

  localparam int DEPTH       = 16;
  // Worst case for one request is an insert at the front with DEPTH - 1 records held.
  localparam int DRAIN_WAIT  = 2 * DEPTH + 8;
  // No legal stretch without a handshake comes near this: the long receiver
  // hold-off of HOLD_CYCLES lies far below it, and random stalls are rarely long.
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int POOL_SIZE   = 20;
  localparam int PHASES      = 12;
  localparam int PHASE_LEN   = 73;

  logic clk;
  logic rst;

  srt_req_if req ();
  srt_rsp_if rsp ();

  int fail_count;
  int pending;
  int checked;

  // Idle behavior of both sides, changed phase by phase from the stimulus process.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  bit hold_done      = 1'b0;

  int quiet_cycles = 0;
  int insert_count = 0;
  int delete_count = 0;

  // Keys used by the random part. A small pool keeps duplicates and delete hits
  // frequent, so the table actually fills up and empties out again.
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  sorted_record_table_core #(.CAPACITY(DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  srt_result_checker #(.CAPACITY(DEPTH)) result_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a run that stops moving for too long is a failure.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no request or result moved for %0d cycles", STALL_LIMIT);
        $display("** sorted_record_table_core: FAILED **");
        $finish;
      end
    end
  end

  // Result side. It normally stalls at random; once, when asked, it holds off
  // for a long stretch that it counts itself, so the block backs up into the
  // request channel while the sender keeps offering requests.
  initial begin : receiver
    int held;
    held      = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        rsp.ready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one request and return at the edge where it is taken. Random idle
  // cycles go in front of it according to send_idle_pct.
  task automatic send_request(input logic op, input logic [KEY_W-1:0] k,
                              input logic [NAME_LOW_W-1:0] nl,
                              input logic [NAME_MID_W-1:0] nm,
                              input logic [NAME_HI_W-1:0] nh);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.cmd       <= op;
    req.key       <= k;
    req.name_low  <= nl;
    req.name_mid  <= nm;
    req.name_high <= nh;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (op == CMD_INSERT) insert_count++;
    else delete_count++;
  endtask

  // Random request with a random name; the name rides along on deletes too.
  task automatic send_random(input logic op, input logic [KEY_W-1:0] k);
    send_request(op, k, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
  endtask

  // Stop offering and wait until every result that is owed has come back.
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Deletes now and then use a key from outside the pool, which almost always
  // misses. Inserts stay inside the pool so that every stored key can be deleted.
  function automatic logic [KEY_W-1:0] pick_key(input logic op);
    if (op == CMD_DELETE && $urandom_range(9) == 0) return $urandom;
    return key_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  initial begin : stimulus
    logic [KEY_W-1:0] fill_keys [14];
    logic             op;
    int               insert_pct;

    rst           = 1'b1;
    req.valid     = 1'b0;
    req.cmd       = CMD_INSERT;
    req.key       = '0;
    req.name_low  = '0;
    req.name_mid  = '0;
    req.name_high = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A delete on the empty table misses, the key extremes go in
    // with all-zero and all-one names, and re-inserting either one is refused.
    send_request(CMD_DELETE, 32'h0000_0000, '0, '0, '0);
    send_request(CMD_INSERT, 32'h0000_0000, '0, '0, '0);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, '1, '1, '1);
    send_random(CMD_INSERT, 32'h0000_0000);
    send_random(CMD_INSERT, 32'hFFFF_FFFF);
    // Fill the table between the two extremes; the order is random, so the new
    // records land at assorted positions and shift the rest up.
    for (int i = 0; i < 14; i++) begin
      fill_keys[i] = $urandom_range(32'hFFFF_FFFE, 32'h0000_0001);
      send_random(CMD_INSERT, fill_keys[i]);
    end
    // The table is full now. A full table refuses even a key it already holds,
    // since the fullness check comes first.
    send_random(CMD_INSERT, 32'h5555_5555);
    send_random(CMD_INSERT, 32'h0000_0000);
    // Delete at the top, at the bottom and in the middle, then miss once more.
    send_random(CMD_DELETE, 32'hFFFF_FFFF);
    send_random(CMD_DELETE, 32'h0000_0000);
    send_random(CMD_DELETE, fill_keys[7]);
    send_random(CMD_DELETE, 32'h5555_5555);
    wait_drained();

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // Random part. Idle modes cycle with period four and the mix of inserts and
    // deletes with period three, so every idle mode meets filling, draining and
    // balanced traffic. Each phase ends with the sender waiting for all results.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      case (ph % 3)
        0:       insert_pct = 85;
        1:       insert_pct = 15;
        default: insert_pct = 50;
      endcase
      // One long hold-off on the result side while requests keep coming.
      if (ph == 2) hold_req <= 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) begin
        op = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
        send_random(op, pick_key(op));
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Ran %0d requests (%0d inserts, %0d deletes) and checked %0d results,",
             insert_count + delete_count, insert_count, delete_count, checked);
    $display("through full and empty tables, duplicates, misses and both-side stalls.");
    if (fail_count == 0) begin
      $display("** sorted_record_table_core: PASSED **");
    end else begin
      $display("** sorted_record_table_core: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/srt_pkg.sv
rtl/core/srt_req_if.sv
rtl/core/srt_rsp_if.sv
rtl/core/srt_mem.sv
rtl/core/srt_seq.sv
rtl/core/sorted_record_table_core.sv
tb/srt_result_checker.sv
tb/tb_sorted_record_table_core.sv
